/* sv/ps2mt_pkg.sv */
// Package for the PS/2 mouse packet tracker.
// Holds widths, register indexes, phase codes and the axis move type.
// No dependencies; the other files, but for the byte channel interface, use it by scoped names.
package ps2mt_pkg;

	// Width of the internal cursor position.
	localparam int COORD_BITS = 12;
	// Width of the cursor fields on the result channel.
	localparam int OUT_BITS = 12;
	// Width of a configuration register.
	localparam int CFG_BITS = 13;
	// Width of the configuration register index.
	localparam int CFG_IDX_BITS = 4;

	// Signed working width for position plus move (moves span -511 to +510).
	localparam int SUM_BITS = ((COORD_BITS > 10) ? COORD_BITS : 10) + 2;
	// Width used to compare a screen limit with the coordinate range.
	localparam int CMP_BITS = (CFG_BITS > COORD_BITS) ? CFG_BITS : COORD_BITS;

	// Configuration register indexes.
	localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_WIDTH  = CFG_IDX_BITS'(0);
	localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_HEIGHT = CFG_IDX_BITS'(1);

	// Configuration reset values.
	localparam logic [CFG_BITS-1:0] SCREEN_WIDTH_RST  = CFG_BITS'(1024);
	localparam logic [CFG_BITS-1:0] SCREEN_HEIGHT_RST = CFG_BITS'(768);

	// Status byte bit positions.
	localparam int ST_LEFT   = 0;
	localparam int ST_RIGHT  = 1;
	localparam int ST_MIDDLE = 2;
	localparam int ST_SYNC   = 3;
	localparam int ST_XSIGN  = 4;
	localparam int ST_YSIGN  = 5;
	localparam int ST_XOVF   = 6;
	localparam int ST_YOVF   = 7;

	// Byte phase codes within a packet.
	localparam logic [1:0] PH_STATUS = 2'd0;
	localparam logic [1:0] PH_XMOVE  = 2'd1;
	localparam logic [1:0] PH_YMOVE  = 2'd2;

	// One axis worth of movement taken from a packet.
	typedef struct packed {
		logic       neg;
		logic       ovf;
		logic [7:0] mag;
	} move_t;

endpackage

/* sv/ps2mt_byte_if.sv */
// Input channel of the PS/2 mouse packet tracker: one raw mouse byte per item.
// Depends on nothing beyond the handshake signals it carries.
interface ps2mt_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

/* sv/ps2mt_cursor_if.sv */
// Result channel of the PS/2 mouse packet tracker: cursor position and buttons.
// Depends on ps2mt_pkg for the field widths.
interface ps2mt_cursor_if;
	logic                          valid;
	logic                          ready;
	logic [ps2mt_pkg::OUT_BITS-1:0] cursor_x;
	logic [ps2mt_pkg::OUT_BITS-1:0] cursor_y;
	logic                          left_pressed;
	logic                          middle_pressed;
	logic                          right_pressed;

	modport source (output valid, output cursor_x, output cursor_y,
		output left_pressed, output middle_pressed, output right_pressed,
		input ready);
	modport sink (input valid, input cursor_x, input cursor_y,
		input left_pressed, input middle_pressed, input right_pressed,
		output ready);
endinterface

/* sv/ps2mt_cfg_if.sv */
// Configuration write channel of the PS/2 mouse packet tracker.
// Depends on ps2mt_pkg for the index and data widths.
interface ps2mt_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [ps2mt_pkg::CFG_IDX_BITS-1:0] index;
	logic [ps2mt_pkg::CFG_BITS-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* sv/ps2mt_axis.sv */
// One cursor axis: applies a packet move to the position and clamps to the screen.
// Depends on ps2mt_pkg. Purely combinational.
module ps2mt_axis (
	input  logic [ps2mt_pkg::COORD_BITS-1:0] pos,
	input  ps2mt_pkg::move_t                 move,
	input  logic                             invert,
	input  logic [ps2mt_pkg::CFG_BITS-1:0]   size,
	output logic [ps2mt_pkg::COORD_BITS-1:0] new_pos
);

	localparam int CB = ps2mt_pkg::COORD_BITS;
	localparam int SB = ps2mt_pkg::SUM_BITS;
	localparam int MB = ps2mt_pkg::CMP_BITS;
	localparam logic [CB-1:0] COORD_MAX = '1;
	localparam logic signed [SB-1:0] OVF_STEP = SB'(255);

	logic signed [8:0]    move9;
	logic signed [SB-1:0] move_ext;
	logic signed [SB-1:0] ovf_adj;
	logic signed [SB-1:0] pos_ext;
	logic signed [SB-1:0] sum;
	logic signed [SB-1:0] lim_ext;
	logic [ps2mt_pkg::CFG_BITS-1:0] size_m1;
	logic [CB-1:0]        lim;

	// The sign bit and magnitude form a 9-bit two's complement move; overflow adds 255 in the direction of the sign.
	always_comb begin
		move9    = $signed({move.neg, move.mag});
		move_ext = SB'(move9);
		if (move.ovf) begin
			ovf_adj = move.neg ? -OVF_STEP : OVF_STEP;
		end else begin
			ovf_adj = '0;
		end
		pos_ext = $signed({{(SB-CB){1'b0}}, pos});
		sum     = invert ? (pos_ext - move_ext - ovf_adj) : (pos_ext + move_ext + ovf_adj);
	end

	// Limit is size minus one, a zero size holds the axis at 0, and the
	// coordinate range caps it.
	always_comb begin
		size_m1 = size - 1'b1;
		if (size == '0) begin
			lim = '0;
		end else if (MB'(size_m1) > MB'(COORD_MAX)) begin
			lim = COORD_MAX;
		end else begin
			lim = CB'(size_m1);
		end
		lim_ext = $signed({{(SB-CB){1'b0}}, lim});
	end

	// Clamp the new position into zero to the limit.
	always_comb begin
		if (sum[SB-1]) begin
			new_pos = '0;
		end else if (sum > lim_ext) begin
			new_pos = lim;
		end else begin
			new_pos = sum[CB-1:0];
		end
	end

endmodule

/* sv/ps2_mouse_packet_tracker.sv */
// Top level of the PS/2 mouse packet tracker: byte framing, position state,
// configuration registers and the result register.
// Depends on ps2mt_pkg, the three channel interfaces and ps2mt_axis.
//
//  Channel  Dir  Carries                                     Handshake
//  mouse    in   data_byte                                   valid/ready
//  cursor   out  cursor_x, cursor_y, left/middle/right       valid/ready
//  cfg      in   index, data (screen_width, screen_height)   valid/ready
//
// One item is accepted per cycle unless a stalled result holds the input
// register. An item enters the input register and is processed from there; the
// third byte of a packet loads the result register, from which the result is
// offered.
// Reset clears the framing state, the position and the result valid flag and
// restores the screen size. A stalled result holds only a third byte in the
// input register; other bytes keep flowing. Configuration is always ready.
module ps2_mouse_packet_tracker (
	input  logic              clk,
	input  logic              arst_n,
	ps2mt_byte_if.sink        mouse,
	ps2mt_cursor_if.source    cursor,
	ps2mt_cfg_if.sink         cfg
);

	localparam int CB = ps2mt_pkg::COORD_BITS;

	logic                             valid_s1;
	logic [7:0]                       byte_s1;
	logic                             skip_q;
	logic [1:0]                       phase_q;
	logic [7:0]                       status_q;
	logic [7:0]                       xmove_q;
	logic [CB-1:0]                    pos_x_q;
	logic [CB-1:0]                    pos_y_q;
	logic [ps2mt_pkg::CFG_BITS-1:0]   width_q;
	logic [ps2mt_pkg::CFG_BITS-1:0]   height_q;
	logic                             out_valid_q;

	logic                             produces;
	logic                             out_free;
	logic                             adv_s1;
	ps2mt_pkg::move_t                 move_x;
	ps2mt_pkg::move_t                 move_y;
	logic [CB-1:0]                    new_x;
	logic [CB-1:0]                    new_y;

	// Handshake: the input register moves on unless its byte makes a result
	// that the full result register cannot take.
	always_comb begin
		produces = valid_s1 && !skip_q && (phase_q == ps2mt_pkg::PH_YMOVE);
		out_free = !out_valid_q || cursor.ready;
		adv_s1   = valid_s1 && (!produces || out_free);
	end

	assign mouse.ready  = !valid_s1 || adv_s1;
	assign cfg.ready    = 1'b1;
	assign cursor.valid = out_valid_q;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (mouse.ready) begin
			valid_s1 <= mouse.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (mouse.valid && mouse.ready) begin
			byte_s1 <= mouse.data_byte;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= ps2mt_pkg::SCREEN_WIDTH_RST;
			height_q <= ps2mt_pkg::SCREEN_HEIGHT_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				ps2mt_pkg::CFG_SCREEN_WIDTH: begin
					width_q <= cfg.data;
				end
				ps2mt_pkg::CFG_SCREEN_HEIGHT: begin
					height_q <= cfg.data;
				end
				default: begin
				end
			endcase
		end
	end

	// Moves for both axes; Y is inverted so that rows grow downward.
	always_comb begin
		move_x.neg = status_q[ps2mt_pkg::ST_XSIGN];
		move_x.ovf = status_q[ps2mt_pkg::ST_XOVF];
		move_x.mag = xmove_q;
		move_y.neg = status_q[ps2mt_pkg::ST_YSIGN];
		move_y.ovf = status_q[ps2mt_pkg::ST_YOVF];
		move_y.mag = byte_s1;
	end

	ps2mt_axis u_axis_x (
		.pos     (pos_x_q),
		.move    (move_x),
		.invert  (1'b0),
		.size    (width_q),
		.new_pos (new_x)
	);

	ps2mt_axis u_axis_y (
		.pos     (pos_y_q),
		.move    (move_y),
		.invert  (1'b1),
		.size    (height_q),
		.new_pos (new_y)
	);

	// Packet framing and position state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q   <= 1'b1;
			phase_q  <= ps2mt_pkg::PH_STATUS;
			status_q <= '0;
			xmove_q  <= '0;
			pos_x_q  <= '0;
			pos_y_q  <= '0;
		end else if (adv_s1) begin
			if (skip_q) begin
				skip_q <= 1'b0;
			end else begin
				unique case (phase_q)
					ps2mt_pkg::PH_STATUS: begin
						if (byte_s1[ps2mt_pkg::ST_SYNC]) begin
							status_q <= byte_s1;
							phase_q  <= ps2mt_pkg::PH_XMOVE;
						end
					end
					ps2mt_pkg::PH_XMOVE: begin
						xmove_q <= byte_s1;
						phase_q <= ps2mt_pkg::PH_YMOVE;
					end
					ps2mt_pkg::PH_YMOVE: begin
						pos_x_q <= new_x;
						pos_y_q <= new_y;
						phase_q <= ps2mt_pkg::PH_STATUS;
					end
					default: begin
						phase_q <= ps2mt_pkg::PH_STATUS;
					end
				endcase
			end
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && produces) begin
			out_valid_q <= 1'b1;
		end else if (cursor.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (adv_s1 && produces) begin
			cursor.cursor_x       <= ps2mt_pkg::OUT_BITS'(new_x);
			cursor.cursor_y       <= ps2mt_pkg::OUT_BITS'(new_y);
			cursor.left_pressed   <= status_q[ps2mt_pkg::ST_LEFT];
			cursor.middle_pressed <= status_q[ps2mt_pkg::ST_MIDDLE];
			cursor.right_pressed  <= status_q[ps2mt_pkg::ST_RIGHT];
		end
	end

	// The startup byte is dropped exactly once.
	a_skip_once: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && skip_q) |=> !skip_q)
		else $error("startup skip flag not cleared after its item");

	// A finished packet returns framing to the status phase and shows a result.
	a_packet_done: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && produces) |=> (out_valid_q && (phase_q == ps2mt_pkg::PH_STATUS)))
		else $error("packet end did not load the result or reset the phase");

	// A byte held in the input register by a stalled result does not change.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |=> (valid_s1 && $stable(byte_s1)))
		else $error("input register item lost while stalled");

endmodule

/* verif/ps2_mouse_packet_tracker_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the PS/2 mouse packet tracker: directed table, then random packets.
// Predicts cursor items in its own tracker and compares them on the result channel.
// Depends on ps2mt_pkg, the three channel interfaces and ps2_mouse_packet_tracker.
module ps2_mouse_packet_tracker_test;

	localparam int TIMEOUT_NS        = 4_000_000;
	localparam int DRAIN_CYCLES      = 4;
	localparam int N_PHASES          = 8;
	localparam int PACKETS_PER_PHASE = 60;
	localparam int LONG_HOLD         = 200;
	localparam int HOLD_SPACING      = 150;
	localparam int MAX_REPORTS       = 10;
	localparam int COORD_MAX         = (1 << ps2mt_pkg::COORD_BITS) - 1;
	localparam logic [ps2mt_pkg::CFG_IDX_BITS-1:0] CFG_UNUSED_IDX = '1;

	// One cursor item as seen on the result channel.
	typedef struct packed {
		logic [ps2mt_pkg::OUT_BITS-1:0] x;
		logic [ps2mt_pkg::OUT_BITS-1:0] y;
		logic                           left;
		logic                           middle;
		logic                           right;
	} cursor_t;

	typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;
	typedef enum int {DRIFT_NONE, DRIFT_DOWN_RIGHT, DRIFT_UP_LEFT} drift_t;

	// A row either sends one mouse byte or writes one register.
	typedef struct packed {
		row_kind_t                          kind;
		logic [ps2mt_pkg::CFG_IDX_BITS-1:0] index;
		logic [ps2mt_pkg::CFG_BITS-1:0]     value;
		logic                               fixed;
		cursor_t                            result;
	} stim_row_t;

	localparam cursor_t NO_CURSOR = '0;
	localparam int N_ROWS = 31;

	// Directed rows. A typed result is given on each third byte whose outcome is plain.
	localparam stim_row_t STIM_TABLE [N_ROWS] = '{
		// Dropped after reset even though the sync bit is set.
		'{ROW_BYTE, '0, 13'h008, 1'b0, NO_CURSOR},
		// Out of sync: bit 3 clear in the status position.
		'{ROW_BYTE, '0, 13'h000, 1'b0, NO_CURSOR},
		'{ROW_BYTE, '0, 13'h008, 1'b0, NO_CURSOR},
		'{ROW_BYTE, '0, 13'h0FF, 1'b0, NO_CURSOR},
		'{ROW_BYTE, '0, 13'h000, 1'b1, '{12'd255, 12'd0, 1'b0, 1'b0, 1'b0}},
		// All buttons held; an upward move is clamped at the top row.
		'{ROW_BYTE, '0, 13'h00F, 1'b0, NO_CURSOR},
		'{ROW_BYTE, '0, 13'h0FF, 1'b0, NO_CURSOR},
		'{ROW_BYTE, '0, 13'h07F, 1'b1, '{12'd510, 12'd0, 1'b1, 1'b1, 1'b1}},
		// X overflow in the positive direction.
		'{ROW_BYTE, '0, 13'h048, 1'b0, NO_CURSOR},
		'{ROW_BYTE, '0, 13'h0FF, 1'b0, NO_CURSOR},
		'{ROW_BYTE, '0, 13'h000, 1'b1, '{12'd1020, 12'd0, 1'b0, 1'b0, 1'b0}},
		// Y overflow with a negative sign moves the cursor down.
		'{ROW_BYTE, '0, 13'h0A8, 1'b0, NO_CURSOR},
		'{ROW_BYTE, '0, 13'h000, 1'b0, NO_CURSOR},
		'{ROW_BYTE, '0, 13'h001, 1'b1, '{12'd1020, 12'd510, 1'b0, 1'b0, 1'b0}},
		// Largest negative moves on both axes; Y hits the bottom row.
		'{ROW_BYTE, '0, 13'h0F8, 1'b0, NO_CURSOR},
		'{ROW_BYTE, '0, 13'h000, 1'b0, NO_CURSOR},
		'{ROW_BYTE, '0, 13'h000, 1'b1, '{12'd509, 12'd767, 1'b0, 1'b0, 1'b0}},
		'{ROW_BYTE, '0, 13'h01A, 1'b0, NO_CURSOR},
		'{ROW_BYTE, '0, 13'h000, 1'b0, NO_CURSOR},
		'{ROW_BYTE, '0, 13'h0FF, 1'b1, '{12'd253, 12'd512, 1'b0, 1'b0, 1'b1}},
		// Zero width holds X at 0; an oversized height is cut to the coordinate range.
		'{ROW_CFG, ps2mt_pkg::CFG_SCREEN_WIDTH, 13'd0, 1'b0, NO_CURSOR},
		'{ROW_CFG, ps2mt_pkg::CFG_SCREEN_HEIGHT, 13'd8191, 1'b0, NO_CURSOR},
		'{ROW_CFG, CFG_UNUSED_IDX, 13'd8191, 1'b0, NO_CURSOR},
		'{ROW_BYTE, '0, 13'h04C, 1'b0, NO_CURSOR},
		'{ROW_BYTE, '0, 13'h0FF, 1'b0, NO_CURSOR},
		'{ROW_BYTE, '0, 13'h080, 1'b1, '{12'd0, 12'd384, 1'b0, 1'b1, 1'b0}},
		'{ROW_CFG, ps2mt_pkg::CFG_SCREEN_WIDTH, 13'd8191, 1'b0, NO_CURSOR},
		'{ROW_CFG, ps2mt_pkg::CFG_SCREEN_HEIGHT, 13'd0, 1'b0, NO_CURSOR},
		'{ROW_BYTE, '0, 13'h048, 1'b0, NO_CURSOR},
		'{ROW_BYTE, '0, 13'h0FF, 1'b0, NO_CURSOR},
		'{ROW_BYTE, '0, 13'h080, 1'b1, '{12'd510, 12'd0, 1'b0, 1'b0, 1'b0}}
	};

	logic clk = 1'b0;
	logic arst_n;

	ps2mt_byte_if   mouse_ch ();
	ps2mt_cursor_if cursor_ch ();
	ps2mt_cfg_if    cfg_ch ();

	ps2_mouse_packet_tracker i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.mouse  (mouse_ch),
		.cursor (cursor_ch),
		.cfg    (cfg_ch)
	);

	always #4 clk = ~clk;

	// Tracker state and register copies, at their reset values.
	logic                            drop_next      = 1'b1;
	logic [1:0]                      frame_phase    = ps2mt_pkg::PH_STATUS;
	logic [7:0]                      held_status    = '0;
	logic [7:0]                      held_dx        = '0;
	logic [ps2mt_pkg::COORD_BITS-1:0] cur_x         = '0;
	logic [ps2mt_pkg::COORD_BITS-1:0] cur_y         = '0;
	logic [ps2mt_pkg::CFG_BITS-1:0]  width_setting  = ps2mt_pkg::SCREEN_WIDTH_RST;
	logic [ps2mt_pkg::CFG_BITS-1:0]  height_setting = ps2mt_pkg::SCREEN_HEIGHT_RST;

	cursor_t expected_cursors [$];
	int      mismatch_count = 0;
	int      cursors_seen   = 0;
	bit      steady_send    = 1'b0;

	// Signed move along one axis, with the extra 255 when the overflow bit is set.
	function automatic int axis_move(input logic [7:0] mag, input logic neg, input logic ovf);
		int d;
		d = int'(mag);
		if (neg)
			d -= 256;
		if (ovf)
			d += neg ? -255 : 255;
		return d;
	endfunction

	// Clamp to the screen; a zero size acts as one and a large one is cut to the range.
	function automatic logic [ps2mt_pkg::COORD_BITS-1:0] clamp_coord(input int v,
			input logic [ps2mt_pkg::CFG_BITS-1:0] size);
		int lim;
		lim = (size == '0) ? 0 : int'(size) - 1;
		if (lim > COORD_MAX)
			lim = COORD_MAX;
		if (v < 0)
			v = 0;
		if (v > lim)
			v = lim;
		return ps2mt_pkg::COORD_BITS'(v);
	endfunction

	// Frames one accepted byte; returns 1 with the cursor item when a packet completes.
	function automatic bit track_mouse_byte(input logic [7:0] b, output cursor_t res);
		int nx, ny;
		res = '0;
		if (drop_next) begin
			drop_next = 1'b0;
			return 1'b0;
		end
		case (frame_phase)
			ps2mt_pkg::PH_STATUS: begin
				if (b[ps2mt_pkg::ST_SYNC]) begin
					held_status = b;
					frame_phase = ps2mt_pkg::PH_XMOVE;
				end
				return 1'b0;
			end
			ps2mt_pkg::PH_XMOVE: begin
				held_dx = b;
				frame_phase = ps2mt_pkg::PH_YMOVE;
				return 1'b0;
			end
			ps2mt_pkg::PH_YMOVE: begin
			end
			default: begin
				frame_phase = ps2mt_pkg::PH_STATUS;
				return 1'b0;
			end
		endcase
		frame_phase = ps2mt_pkg::PH_STATUS;
		nx = int'(cur_x) + axis_move(held_dx, held_status[ps2mt_pkg::ST_XSIGN],
			held_status[ps2mt_pkg::ST_XOVF]);
		ny = int'(cur_y) - axis_move(b, held_status[ps2mt_pkg::ST_YSIGN],
			held_status[ps2mt_pkg::ST_YOVF]);
		cur_x = clamp_coord(nx, width_setting);
		cur_y = clamp_coord(ny, height_setting);
		res.x      = ps2mt_pkg::OUT_BITS'(cur_x);
		res.y      = ps2mt_pkg::OUT_BITS'(cur_y);
		res.left   = held_status[ps2mt_pkg::ST_LEFT];
		res.middle = held_status[ps2mt_pkg::ST_MIDDLE];
		res.right  = held_status[ps2mt_pkg::ST_RIGHT];
		return 1'b1;
	endfunction

	// Idle stretch length: mostly short, now and then long.
	function automatic int idle_length();
		return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
	endfunction

	function automatic int sender_gap();
		return (steady_send || $urandom_range(0, 1) == 0) ? 0 : idle_length();
	endfunction

	function automatic logic [ps2mt_pkg::CFG_BITS-1:0] pick_size();
		return ($urandom_range(0, 7) == 0)
			? ps2mt_pkg::CFG_BITS'($urandom_range(0, 8191))
			: ps2mt_pkg::CFG_BITS'($urandom_range(1, 4096));
	endfunction

	// Offers one byte from a falling edge and records what it should produce.
	task automatic send_byte(input logic [7:0] b, input bit fixed, input cursor_t fixed_cursor);
		int      gap;
		cursor_t predicted;
		gap = sender_gap();
		repeat (gap) begin
			mouse_ch.valid <= 1'b0;
			@(negedge clk);
		end
		mouse_ch.valid     <= 1'b1;
		mouse_ch.data_byte <= b;
		@(posedge clk);
		while (!mouse_ch.ready)
			@(posedge clk);
		@(negedge clk);
		if (track_mouse_byte(b, predicted))
			expected_cursors.push_back(fixed ? fixed_cursor : predicted);
	endtask

	// Writes one register, then drops the channel's valid before returning.
	task automatic write_reg(input logic [ps2mt_pkg::CFG_IDX_BITS-1:0] idx,
			input logic [ps2mt_pkg::CFG_BITS-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		case (idx)
			ps2mt_pkg::CFG_SCREEN_WIDTH:  width_setting = value;
			ps2mt_pkg::CFG_SCREEN_HEIGHT: height_setting = value;
			default: begin
			end
		endcase
		@(negedge clk);
	endtask

	// Stops sending, waits for every expected item, then waits out DRAIN_CYCLES.
	task automatic wait_idle();
		mouse_ch.valid <= 1'b0;
		while (expected_cursors.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES)
			@(negedge clk);
	endtask

	task automatic log_failure(input string what, input cursor_t want, input cursor_t got);
		if (mismatch_count < MAX_REPORTS)
			$display("%0t: %s: expected x=%0d y=%0d lmr=%b%b%b, got x=%0d y=%0d lmr=%b%b%b",
				$time, what, want.x, want.y, want.left, want.middle, want.right,
				got.x, got.y, got.left, got.middle, got.right);
		mismatch_count++;
	endtask

	// Compares each accepted cursor item with the oldest expectation.
	always @(posedge clk) begin : check_cursor
		cursor_t got;
		cursor_t want;
		if (arst_n && cursor_ch.valid && cursor_ch.ready) begin
			got = '{cursor_ch.cursor_x, cursor_ch.cursor_y, cursor_ch.left_pressed,
				cursor_ch.middle_pressed, cursor_ch.right_pressed};
			cursors_seen++;
			if (expected_cursors.size() == 0) begin
				log_failure("unexpected cursor item", NO_CURSOR, got);
			end else begin
				want = expected_cursors.pop_front();
				if (got.x !== want.x || got.y !== want.y || got.left !== want.left
						|| got.middle !== want.middle || got.right !== want.right)
					log_failure("cursor mismatch", want, got);
			end
		end
	end

	// Receiver: random stalls, quiet stretches, and a long hold-off now and then.
	initial begin : drive_cursor_ready
		int stall_left;
		int hold_left;
		int next_hold_at;
		int steady_left;
		bit steady;
		stall_left   = 0;
		hold_left    = 0;
		next_hold_at = 60;
		steady_left  = 0;
		steady       = 1'b0;
		cursor_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (steady_left == 0) begin
				steady      = ($urandom_range(0, 3) == 0);
				steady_left = $urandom_range(32, 128);
			end else begin
				steady_left--;
			end
			if (arst_n && cursors_seen >= next_hold_at) begin
				hold_left    = LONG_HOLD;
				next_hold_at += HOLD_SPACING;
			end
			if (hold_left > 0)
				hold_left--;
			else if (stall_left > 0)
				stall_left--;
			else if (!steady && $urandom_range(0, 3) == 0)
				stall_left = idle_length();
			cursor_ch.ready <= (hold_left == 0) && (stall_left == 0);
		end
	end

	// Stimulus: reset, the directed table, then random phases with fresh screen sizes.
	initial begin : stimulus
		logic [ps2mt_pkg::CFG_BITS-1:0] w;
		logic [ps2mt_pkg::CFG_BITS-1:0] h;
		logic [7:0]                     status;
		drift_t                         drift;
		arst_n             = 1'b0;
		mouse_ch.valid     = 1'b0;
		mouse_ch.data_byte = '0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.index       = '0;
		cfg_ch.data        = '0;
		repeat (5)
			@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < N_ROWS; i++) begin
			if (STIM_TABLE[i].kind == ROW_CFG) begin
				wait_idle();
				write_reg(STIM_TABLE[i].index, STIM_TABLE[i].value);
			end else begin
				send_byte(STIM_TABLE[i].value[7:0], STIM_TABLE[i].fixed, STIM_TABLE[i].result);
			end
		end

		for (int p = 0; p < N_PHASES; p++) begin
			wait_idle();
			// The first phases take the extreme sizes, the rest random ones.
			case (p)
				0: begin w = 13'd1;    h = 13'd1;    end
				1: begin w = 13'd8191; h = 13'd8191; end
				2: begin w = 13'd0;    h = 13'd4096; end
				3: begin w = 13'd4096; h = 13'd0;    end
				default: begin w = pick_size(); h = pick_size(); end
			endcase
			write_reg(ps2mt_pkg::CFG_SCREEN_WIDTH, w);
			write_reg(ps2mt_pkg::CFG_SCREEN_HEIGHT, h);
			drift = drift_t'($urandom_range(0, 2));
			for (int k = 0; k < PACKETS_PER_PHASE; k++) begin
				if ($urandom_range(0, 15) == 0)
					steady_send = !steady_send;
				// A stray byte now and then knocks the framing out of step.
				if ($urandom_range(0, 7) == 0)
					send_byte(8'($urandom_range(0, 255)), 1'b0, NO_CURSOR);
				status = 8'($urandom_range(0, 255));
				status[ps2mt_pkg::ST_SYNC] = 1'b1;
				// Drifting phases push the cursor towards one corner to reach the limits.
				if (drift != DRIFT_NONE && $urandom_range(0, 9) < 7) begin
					status[ps2mt_pkg::ST_XOVF]  = 1'b1;
					status[ps2mt_pkg::ST_YOVF]  = 1'b1;
					status[ps2mt_pkg::ST_XSIGN] = (drift == DRIFT_UP_LEFT);
					status[ps2mt_pkg::ST_YSIGN] = (drift == DRIFT_DOWN_RIGHT);
				end
				send_byte(status, 1'b0, NO_CURSOR);
				send_byte(8'($urandom_range(0, 255)), 1'b0, NO_CURSOR);
				send_byte(8'($urandom_range(0, 255)), 1'b0, NO_CURSOR);
			end
		end

		wait_idle();
		if (mismatch_count == 0 && expected_cursors.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("Simulation FAILED");
		$finish;
	end

endmodule
